@@ rtl/pemt_pkg.sv @@
// ----------------------------------------------------------------------------
// pemt_pkg
// Shared widths, opcodes, status codes and the result word type of the
// packed entity mask table.
// ----------------------------------------------------------------------------
`default_nettype none

package pemt_pkg;

	localparam int OPCODE_W   = 3;
	localparam int INDEX_W    = 6;
	localparam int BITS_W     = 16;
	localparam int STATUS_W   = 2;
	localparam int RINDEX_W   = 7;
	localparam int COUNT_W    = 7;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int MASK_BITS_DEF   = 16;

	localparam logic [OPCODE_W-1:0] OP_CREATE  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_DESTROY = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_ADD     = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_REMOVE  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_ANY     = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_ALL     = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_LIVE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [RINDEX_W-1:0] result_index;
		logic                entry_moved;
		logic                query_answer;
		logic [COUNT_W-1:0]  live_entries;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/pemt_req_if.sv @@
// ----------------------------------------------------------------------------
// pemt_req_if
// Request channel: one operation word with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pemt_req_if import pemt_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [INDEX_W-1:0]  entity_index;
	logic [BITS_W-1:0]   component_bits;

	modport source (
		output valid, opcode, entity_index, component_bits,
		input  ready
	);

	modport sink (
		input  valid, opcode, entity_index, component_bits,
		output ready
	);

endinterface

`default_nettype wire

@@ rtl/pemt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// pemt_rsp_if
// Response channel: one result word with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pemt_rsp_if import pemt_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [RINDEX_W-1:0] result_index;
	logic                entry_moved;
	logic                query_answer;
	logic [COUNT_W-1:0]  live_entries;

	modport source (
		output valid, status, result_index, entry_moved, query_answer, live_entries,
		input  ready
	);

	modport sink (
		input  valid, status, result_index, entry_moved, query_answer, live_entries,
		output ready
	);

endinterface

`default_nettype wire

@@ rtl/pemt_mask_mem.sv @@
// ----------------------------------------------------------------------------
// pemt_mask_mem
// Mask store: one write port, two registered read ports. A read that hits
// the address written at the same edge returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module pemt_mask_mem import pemt_pkg::*; #(
	parameter int DEPTH = MAX_ENTRIES_DEF,
	parameter int WIDTH = MASK_BITS_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr_a,
	input  wire logic [AW-1:0]    rd_addr_b,
	output logic      [WIDTH-1:0] rd_data_a,
	output logic      [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// write-through bypass so back-to-back words see each other's update
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
			rd_data_b <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
		end
	end

endmodule

`default_nettype wire

@@ rtl/pemt_exec.sv @@
// ----------------------------------------------------------------------------
// pemt_exec
// Operation logic: decodes one operation against the live count and the two
// masks read for it, and produces the result word, the store update and the
// new live count.
// ----------------------------------------------------------------------------
`default_nettype none

module pemt_exec import pemt_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int MASK_BITS   = MASK_BITS_DEF,
	localparam int AW         = $clog2(MAX_ENTRIES),
	localparam int CW         = $clog2(MAX_ENTRIES + 1)
) (
	input  wire logic [OPCODE_W-1:0]  opcode,
	input  wire logic [INDEX_W-1:0]   entity_index,
	input  wire logic [MASK_BITS-1:0] bits,
	input  wire logic [CW-1:0]        live_count,
	input  wire logic [MASK_BITS-1:0] mask_idx,
	input  wire logic [MASK_BITS-1:0] mask_last,
	output result_t                   result,
	output logic      [CW-1:0]        live_next,
	output logic                      wr_en,
	output logic      [AW-1:0]        wr_addr,
	output logic      [MASK_BITS-1:0] wr_data
);

	localparam int XW = CW + INDEX_W;

	logic [XW-1:0]        idx_wide;
	logic [XW-1:0]        last_wide;
	logic [CW-1:0]        last;
	logic                 live;
	logic                 full;
	logic                 bits_zero;
	logic [MASK_BITS-1:0] hit;

	always_comb begin
		idx_wide  = XW'(entity_index);
		last      = CW'(live_count - CW'(1));
		last_wide = XW'(last);
		live      = idx_wide < XW'(live_count);
		full      = live_count >= CW'(MAX_ENTRIES);
		bits_zero = bits == '0;
		hit       = mask_idx & bits;

		result       = '0;
		result.status = ST_OK;
		live_next    = live_count;
		wr_en        = 1'b0;
		wr_addr      = idx_wide[AW-1:0];
		wr_data      = '0;

		case (opcode)
			OP_CREATE: begin
				if (full) begin
					result.status       = ST_FULL;
					result.result_index = RINDEX_W'(MAX_ENTRIES);
				end else begin
					result.result_index = RINDEX_W'(live_count);
					wr_en     = 1'b1;
					wr_addr   = live_count[AW-1:0];
					wr_data   = '0;
					live_next = CW'(live_count + CW'(1));
				end
			end
			OP_DESTROY: begin
				if (!live) begin
					result.status = ST_NOT_LIVE;
				end else begin
					live_next = last;
					// last slot needs no clear: create zeroes a slot before it goes live
					if (idx_wide != last_wide) begin
						wr_en               = 1'b1;
						wr_data             = mask_last;
						result.entry_moved  = 1'b1;
						result.result_index = RINDEX_W'(last);
					end
				end
			end
			OP_ADD, OP_REMOVE: begin
				if (!live) begin
					result.status = ST_NOT_LIVE;
				end else if (bits_zero) begin
					result.status = ST_EMPTY;
				end else begin
					wr_en   = 1'b1;
					wr_data = (opcode == OP_ADD) ? (mask_idx | bits) : (mask_idx & ~bits);
				end
			end
			OP_ANY: begin
				if (!live) begin
					result.status = ST_NOT_LIVE;
				end else begin
					result.query_answer = hit != '0;
				end
			end
			OP_ALL: begin
				if (!live) begin
					result.status = ST_NOT_LIVE;
				end else begin
					result.query_answer = hit == bits;
				end
			end
			default: begin
				result.status = ST_OK;
			end
		endcase

		result.live_entries = COUNT_W'(live_next);
	end

endmodule

`default_nettype wire

@@ rtl/packed_entity_mask_table_core.sv @@
// An accepted request word is registered in stage s1 and its response word
// when it retires. One operation per cycle, back to back, while rsp.ready
// holds; the two-port mask store is read at accept and updated at retire.
// Reset: arst_n clears the live count and the valid flags; mask contents
// are not cleared, create zeroes a slot before it becomes live.
// ----------------------------------------------------------------------------
// packed_entity_mask_table_core
// Densely packed table of live entries, each with a bit mask: create,
// swap-and-pop destroy, bit add/remove and any/all queries.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_entity_mask_table_core import pemt_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int MASK_BITS   = MASK_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pemt_req_if.sink   req,
	pemt_rsp_if.source rsp
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int XW = CW + INDEX_W;
	localparam int BW = MASK_BITS + BITS_W;

	logic                 valid_s1;
	logic [OPCODE_W-1:0]  opcode_s1;
	logic [INDEX_W-1:0]   index_s1;
	logic [MASK_BITS-1:0] bits_s1;
	logic [MASK_BITS-1:0] mask_idx_s1;
	logic [MASK_BITS-1:0] mask_last_s1;

	logic [CW-1:0]        live_count_q;
	logic                 rsp_valid_q;
	result_t              rsp_word_q;

	logic                 fire;
	logic                 accept;
	logic [CW-1:0]        live_eff;
	logic [CW-1:0]        last_eff;
	logic [XW-1:0]        req_idx_wide;
	logic [BW-1:0]        req_bits_wide;

	result_t              result;
	logic [CW-1:0]        live_next;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [MASK_BITS-1:0] wr_data;

	assign fire      = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || fire;
	assign accept    = req.valid && req.ready;

	// count seen by the word being accepted includes the retiring word's effect
	assign live_eff      = fire ? live_next : live_count_q;
	assign last_eff      = CW'(live_eff - CW'(1));
	assign req_idx_wide  = XW'(req.entity_index);
	assign req_bits_wide = BW'(req.component_bits);

	pemt_mask_mem #(
		.DEPTH (MAX_ENTRIES),
		.WIDTH (MASK_BITS)
	) u_mem (
		.clk       (clk),
		.wr_en     (wr_en && fire),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (accept),
		.rd_addr_a (req_idx_wide[AW-1:0]),
		.rd_addr_b (last_eff[AW-1:0]),
		.rd_data_a (mask_idx_s1),
		.rd_data_b (mask_last_s1)
	);

	pemt_exec #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.MASK_BITS   (MASK_BITS)
	) u_exec (
		.opcode       (opcode_s1),
		.entity_index (index_s1),
		.bits         (bits_s1),
		.live_count   (live_count_q),
		.mask_idx     (mask_idx_s1),
		.mask_last    (mask_last_s1),
		.result       (result),
		.live_next    (live_next),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			live_count_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				live_count_q <= live_next;
				rsp_valid_q  <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= req.opcode;
			index_s1  <= req.entity_index;
			bits_s1   <= req_bits_wide[MASK_BITS-1:0];
		end
		if (fire) begin
			rsp_word_q <= result;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_word_q.status;
	assign rsp.result_index = rsp_word_q.result_index;
	assign rsp.entry_moved  = rsp_word_q.entry_moved;
	assign rsp.query_answer = rsp_word_q.query_answer;
	assign rsp.live_entries = rsp_word_q.live_entries;

endmodule

`default_nettype wire
